/* sv/rbca_pkg.sv */
// Shared types, constants and helpers for the reorder buffer with cumulative ACK.
// Used by every module of the block; depends on nothing.
package rbca_pkg;

    // Slot store and length limit
    localparam int SLOTS       = 32;
    localparam int SLOT_AW     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int MAX_PAYLOAD = 1024;

    // Queue between front end and engine
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    // Result kinds
    localparam logic KIND_DELIVER = 1'b0;
    localparam logic KIND_ACK     = 1'b1;

    typedef logic [63:0] t_seq;
    typedef logic [15:0] t_len;
    typedef logic [15:0] t_tag;

    // One arriving segment
    typedef struct packed {
        t_seq seq;
        t_len len;
        t_tag tag;
    } t_seg;

    // One result beat
    typedef struct packed {
        logic kind;
        t_tag tag;
        t_len len;
        t_seq ack;
        logic last;
    } t_result;

    // Engine sequencer
    typedef enum logic [2:0] {
        S_IDLE,
        S_CLASS,
        S_ACT,
        S_SCAN,
        S_PICK
    } t_eng_state;

    // Lowest set bit of a slot vector
    function automatic logic [SLOT_AW-1:0] first_set(input logic [SLOTS-1:0] vec);
        logic [SLOT_AW-1:0] idx;
        idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (vec[i]) begin
                idx = SLOT_AW'(i);
            end
        end
        return idx;
    endfunction

endpackage

/* sv/rbca_front.sv */
// Front end: input register that takes segments and drops those with a bad length.
// Feeds the segment queue; uses rbca_pkg.
module rbca_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          push,
    output logic          full,
    input  rbca_pkg::t_seq i_seq_number,
    input  rbca_pkg::t_len i_payload_length,
    input  rbca_pkg::t_tag i_payload_tag,
    output logic          o_q_wr,
    output rbca_pkg::t_seg o_q_seg,
    input  logic          i_q_full
);
    import rbca_pkg::*;

    logic r_valid;
    t_seg r_seg;
    logic accept;
    logic len_ok;

    // Length filter: zero or above the limit never enters the queue
    assign len_ok = (i_payload_length != '0) && (i_payload_length <= 16'(MAX_PAYLOAD));
    assign full   = r_valid && i_q_full;
    assign accept = push && !full;

    assign o_q_wr  = r_valid && !i_q_full;
    assign o_q_seg = r_seg;

    // Holding register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= len_ok;
        end else if (o_q_wr) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_seg <= '{seq: i_seq_number, len: i_payload_length, tag: i_payload_tag};
        end
    end

endmodule

/* sv/rbca_fifo.sv */
// Short segment queue between front end and engine.
// Depth from rbca_pkg::QDEPTH; uses rbca_pkg.
module rbca_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr,
    input  rbca_pkg::t_seg i_wr_seg,
    output logic           o_full,
    input  logic           i_rd,
    output rbca_pkg::t_seg o_rd_seg,
    output logic           o_empty
);
    import rbca_pkg::*;

    t_seg           r_mem [QDEPTH];
    logic [QAW-1:0] r_wptr;
    logic [QAW-1:0] r_rptr;
    logic [QAW:0]   r_count;
    logic           do_wr;
    logic           do_rd;

    assign o_full   = (r_count == (QAW+1)'(QDEPTH));
    assign o_empty  = (r_count == '0);
    assign do_wr    = i_wr && !o_full;
    assign do_rd    = i_rd && !o_empty;
    assign o_rd_seg = r_mem[r_rptr];

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_wr) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (do_rd) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (do_wr && !do_rd) begin
                r_count <= r_count + 1'b1;
            end else if (do_rd && !do_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wptr] <= i_wr_seg;
        end
    end

endmodule

/* sv/rbca_engine.sv */
// Engine: slot store, expected number, chained delivery and result register.
// Takes segments from rbca_fifo; uses rbca_pkg.
module rbca_engine (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_empty,
    input  rbca_pkg::t_seg   i_q_seg,
    output logic             o_q_rd,
    output rbca_pkg::t_result o_res,
    output logic             o_res_valid,
    input  logic             i_res_pop
);
    import rbca_pkg::*;

    t_eng_state       r_state, n_state;
    t_seq             r_ne, n_ne;
    t_seg             r_seg;
    logic             r_lt;
    logic             r_eq;
    logic [SLOTS-1:0] r_hit;
    logic [SLOTS-1:0] r_free;
    logic [SLOTS-1:0] r_slot_valid;
    t_seq             r_slot_seq [SLOTS];
    t_len             r_slot_len [SLOTS];
    t_tag             r_slot_tag [SLOTS];
    logic             r_out_valid;
    t_result          r_out, n_out;
    logic             out_load;
    logic             out_ok;
    t_seq             cmp_key;
    logic [SLOTS-1:0] hit_vec;
    logic             slot_wr;
    logic             slot_clr;
    logic [SLOT_AW-1:0] free_idx;
    logic [SLOT_AW-1:0] hit_idx;

    assign out_ok      = !r_out_valid || i_res_pop;
    assign o_res       = r_out;
    assign o_res_valid = r_out_valid;
    assign free_idx    = first_set(r_free);
    assign hit_idx     = first_set(r_hit);

    // Parallel slot compare against the segment or the expected number
    assign cmp_key = (r_state == S_CLASS) ? r_seg.seq : r_ne;
    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            hit_vec[i] = r_slot_valid[i] && (r_slot_seq[i] == cmp_key);
        end
    end

    // Sequencer: next state, result and slot updates
    always_comb begin
        n_state  = r_state;
        n_ne     = r_ne;
        n_out    = r_out;
        out_load = 1'b0;
        slot_wr  = 1'b0;
        slot_clr = 1'b0;
        o_q_rd   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    o_q_rd  = 1'b1;
                    n_state = S_CLASS;
                end
            end
            S_CLASS: begin
                n_state = S_ACT;
            end
            S_ACT: begin
                priority if (r_lt) begin
                    // behind: ACK only
                    if (out_ok) begin
                        out_load = 1'b1;
                        n_out    = '{kind: KIND_ACK, tag: '0, len: '0, ack: r_ne, last: 1'b1};
                        n_state  = S_IDLE;
                    end
                end else if (r_eq) begin
                    // in order: deliver, then look for the next slot
                    if (out_ok) begin
                        out_load = 1'b1;
                        n_out    = '{kind: KIND_DELIVER, tag: r_seg.tag, len: r_seg.len,
                                     ack: '0, last: 1'b0};
                        n_ne     = r_ne + 64'(r_seg.len);
                        n_state  = S_SCAN;
                    end
                end else begin
                    // ahead: store unless already held or no room
                    slot_wr = !(|r_hit) && (|r_free);
                    n_state = S_IDLE;
                end
            end
            S_SCAN: begin
                n_state = S_PICK;
            end
            S_PICK: begin
                if (out_ok) begin
                    out_load = 1'b1;
                    if (|r_hit) begin
                        slot_clr = 1'b1;
                        n_out    = '{kind: KIND_DELIVER, tag: r_slot_tag[hit_idx],
                                     len: r_slot_len[hit_idx], ack: '0, last: 1'b0};
                        n_ne     = r_ne + 64'(r_slot_len[hit_idx]);
                        n_state  = S_SCAN;
                    end else begin
                        n_out   = '{kind: KIND_ACK, tag: '0, len: '0, ack: r_ne, last: 1'b1};
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_ne         <= '0;
            r_out_valid  <= 1'b0;
            r_slot_valid <= '0;
        end else begin
            r_state <= n_state;
            r_ne    <= n_ne;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_res_pop) begin
                r_out_valid <= 1'b0;
            end
            if (slot_wr) begin
                r_slot_valid[free_idx] <= 1'b1;
            end
            if (slot_clr) begin
                r_slot_valid[hit_idx] <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (o_q_rd) begin
            r_seg <= i_q_seg;
        end
        if (r_state == S_CLASS) begin
            r_lt   <= r_seg.seq < r_ne;
            r_eq   <= r_seg.seq == r_ne;
            r_free <= ~r_slot_valid;
        end
        if (r_state == S_CLASS || r_state == S_SCAN) begin
            r_hit <= hit_vec;
        end
        if (out_load) begin
            r_out <= n_out;
        end
        if (slot_wr) begin
            r_slot_seq[free_idx] <= r_seg.seq;
            r_slot_len[free_idx] <= r_seg.len;
            r_slot_tag[free_idx] <= r_seg.tag;
        end
    end

    // Behind segment always closes with a final ACK
    a_behind_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ACT && r_lt && out_ok) |=>
            (r_state == S_IDLE && r_out_valid && r_out.last && r_out.kind == KIND_ACK))
        else $error("behind segment did not produce a final ACK");

    // Expected number moves only on a delivery
    a_ne_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_state == S_ACT || r_state == S_PICK) |=> $stable(r_ne))
        else $error("expected number changed outside a delivery");

    // Match vector only names valid slots when it is used
    a_hit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PICK || r_state == S_ACT) |-> ((r_hit & ~r_slot_valid) == '0))
        else $error("slot match on an empty slot");

    // Slots are freed only by chained delivery
    a_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_PICK) |=>
            ($countones(r_slot_valid) >= $countones($past(r_slot_valid))))
        else $error("slot freed outside chained delivery");

endmodule

/* sv/reorder_buffer_cumulative_ack_core.sv */
// Top level of the reorder buffer with cumulative ACK.
// Instantiates rbca_front, rbca_fifo and rbca_engine; uses rbca_pkg.
//
// Segments enter through a push/full queue port and results leave through an
// empty/pop queue port; each result beat is a delivery (result_kind 0) or a
// cumulative ACK (result_kind 1), and last marks the final beat of a segment.
// Segments with a zero length or a length above MAX_PAYLOAD are taken and
// dropped at the front end. The engine handles one segment at a time: a
// segment behind or ahead of the expected number passes through the classify
// and act states, an in-order segment also through a scan and a pick step for
// each buffered slot delivered in the chain and for the closing ACK, each
// result beat waiting further while the result register is still held. The
// compare/select step of the engine works over the 32 slots. A four-entry queue
// lets the input side keep taking segments while the engine is busy. Reset
// clears the slot valid bits at once; there is no clearing pass.
module reorder_buffer_cumulative_ack_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           push,
    output logic           full,
    input  rbca_pkg::t_seq i_seq_number,
    input  rbca_pkg::t_len i_payload_length,
    input  rbca_pkg::t_tag i_payload_tag,
    output logic           empty,
    input  logic           pop,
    output logic           o_result_kind,
    output rbca_pkg::t_tag o_out_tag,
    output rbca_pkg::t_len o_out_length,
    output rbca_pkg::t_seq o_ack_number,
    output logic           o_last
);
    import rbca_pkg::*;

    logic    q_wr;
    t_seg    q_wr_seg;
    logic    q_full;
    logic    q_rd;
    t_seg    q_rd_seg;
    logic    q_empty;
    t_result res;
    logic    res_valid;

    // Front end
    rbca_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .push             (push),
        .full             (full),
        .i_seq_number     (i_seq_number),
        .i_payload_length (i_payload_length),
        .i_payload_tag    (i_payload_tag),
        .o_q_wr           (q_wr),
        .o_q_seg          (q_wr_seg),
        .i_q_full         (q_full)
    );

    // Segment queue
    rbca_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (q_wr),
        .i_wr_seg (q_wr_seg),
        .o_full   (q_full),
        .i_rd     (q_rd),
        .o_rd_seg (q_rd_seg),
        .o_empty  (q_empty)
    );

    // Engine
    rbca_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_q_seg     (q_rd_seg),
        .o_q_rd      (q_rd),
        .o_res       (res),
        .o_res_valid (res_valid),
        .i_res_pop   (pop)
    );

    // Result port
    assign empty         = !res_valid;
    assign o_result_kind = res.kind;
    assign o_out_tag     = res.tag;
    assign o_out_length  = res.len;
    assign o_ack_number  = res.ack;
    assign o_last        = res.last;

endmodule
